// File: rtl/gdt_pkg.sv
package gdt_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_DEGREE_DEF   = 16;
  localparam logic [4:0] VCOUNT_RESET = 5'd10;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_DFS   = 2'd2,
    CMD_BFS   = 2'd3
  } gdt_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_ADD_W2,
    ST_START,
    ST_DFS_TOP,
    ST_DFS_RD,
    ST_DFS_CHK,
    ST_BFS_POP,
    ST_BFS_NB,
    ST_BFS_RD,
    ST_BFS_CHK,
    ST_FINISH
  } gdt_state_t;

  // which vertex addresses the degree table this cycle
  typedef enum logic [2:0] {
    DSEL_A,
    DSEL_B,
    DSEL_S,
    DSEL_W,
    DSEL_Q
  } gdt_dsel_t;

  typedef struct packed {
    logic      accept;
    logic      clear;
    logic      run_init;
    logic      add_cap;
    logic      add_first;
    logic      add_second;
    logic      set_drop;
    logic      s_inc;
    logic      visit;
    logic      visit_start;
    logic      dfs_start;
    logic      bfs_start;
    logic      sp_dec;
    logic      pos_dec;
    logic      dfs_push;
    logic      bfs_pop;
    logic      bfs_read;
    logic      bfs_enq;
    logic      flush;
    gdt_dsel_t deg_sel;
  } gdt_ctl_t;

  typedef struct packed {
    logic mode_dfs;
    logic add_ok;
    logic s_done;
    logic s_marked;
    logic sp_zero;
    logic top_pos_zero;
    logic w_new_dfs;
    logic w_new_bfs;
    logic q_empty;
    logic k_zero;
    logic pend_valid;
    logic out_free;
  } gdt_status_t;

endpackage

// File: rtl/gdt_ctrl.sv
module gdt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           command,
  input  gdt_pkg::gdt_status_t st,
  output gdt_pkg::gdt_ctl_t    ctl,
  output logic                 in_stall
);
  import gdt_pkg::*;

  gdt_state_t state, state_next;
  logic       vis_ok;

  assign vis_ok   = !st.pend_valid || st.out_free;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (gdt_cmd_t'(command))
            CMD_CLEAR: state_next = ST_IDLE;
            CMD_ADD:   state_next = ST_ADD_A;
            default:   state_next = ST_START;
          endcase
        end
      end
      ST_ADD_A:   state_next = ST_ADD_B;
      ST_ADD_B:   state_next = st.add_ok ? ST_ADD_W2 : ST_IDLE;
      ST_ADD_W2:  state_next = ST_IDLE;
      ST_START: begin
        if (st.s_done) begin
          state_next = ST_FINISH;
        end else if (!st.s_marked && vis_ok) begin
          state_next = st.mode_dfs ? ST_DFS_TOP : ST_BFS_POP;
        end
      end
      ST_DFS_TOP: begin
        if (st.sp_zero) begin
          state_next = ST_START;
        end else if (!st.top_pos_zero) begin
          state_next = ST_DFS_RD;
        end
      end
      ST_DFS_RD:  state_next = ST_DFS_CHK;
      ST_DFS_CHK: begin
        if (!st.w_new_dfs || vis_ok) begin
          state_next = ST_DFS_TOP;
        end
      end
      ST_BFS_POP: state_next = st.q_empty ? ST_START : ST_BFS_NB;
      ST_BFS_NB:  state_next = st.k_zero ? ST_BFS_POP : ST_BFS_RD;
      ST_BFS_RD:  state_next = ST_BFS_CHK;
      ST_BFS_CHK: begin
        if (!st.w_new_bfs || vis_ok) begin
          state_next = ST_BFS_NB;
        end
      end
      ST_FINISH: begin
        if (!st.pend_valid || st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.deg_sel = DSEL_A;
    unique case (state)
      ST_IDLE: begin
        ctl.accept = in_valid;
        if (in_valid) begin
          unique case (gdt_cmd_t'(command))
            CMD_CLEAR: ctl.clear = 1'b1;
            CMD_ADD:   ctl.clear = 1'b0;
            default:   ctl.run_init = 1'b1;
          endcase
        end
      end
      ST_ADD_A: begin
        ctl.deg_sel = DSEL_A;
        ctl.add_cap = 1'b1;
      end
      ST_ADD_B: begin
        ctl.deg_sel   = DSEL_B;
        ctl.add_first = st.add_ok;
        ctl.set_drop  = !st.add_ok;
      end
      ST_ADD_W2: begin
        ctl.deg_sel    = DSEL_B;
        ctl.add_second = 1'b1;
      end
      ST_START: begin
        ctl.deg_sel = DSEL_S;
        if (!st.s_done) begin
          if (st.s_marked) begin
            ctl.s_inc = 1'b1;
          end else if (vis_ok) begin
            ctl.s_inc       = 1'b1;
            ctl.visit       = 1'b1;
            ctl.visit_start = 1'b1;
            ctl.dfs_start   = st.mode_dfs;
            ctl.bfs_start   = !st.mode_dfs;
          end
        end
      end
      ST_DFS_TOP: begin
        if (!st.sp_zero) begin
          ctl.sp_dec  = st.top_pos_zero;
          ctl.pos_dec = !st.top_pos_zero;
        end
      end
      ST_DFS_RD: ctl.deg_sel = DSEL_W;
      ST_DFS_CHK: begin
        ctl.deg_sel = DSEL_W;
        if (st.w_new_dfs && vis_ok) begin
          ctl.visit    = 1'b1;
          ctl.dfs_push = 1'b1;
        end
      end
      ST_BFS_POP: begin
        ctl.deg_sel = DSEL_Q;
        ctl.bfs_pop = !st.q_empty;
      end
      ST_BFS_NB:  ctl.bfs_read = !st.k_zero;
      ST_BFS_RD:  ctl.deg_sel = DSEL_W;
      ST_BFS_CHK: begin
        ctl.deg_sel = DSEL_W;
        if (st.w_new_bfs && vis_ok) begin
          ctl.visit   = 1'b1;
          ctl.bfs_enq = 1'b1;
        end
      end
      ST_FINISH: ctl.flush = st.pend_valid && st.out_free;
      default:   ctl.deg_sel = DSEL_A;
    endcase
  end

endmodule

// File: rtl/gdt_datapath.sv
module gdt_datapath #(
  parameter int MAX_VERTICES = gdt_pkg::MAX_VERTICES_DEF,
  parameter int MAX_DEGREE   = gdt_pkg::MAX_DEGREE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gdt_pkg::gdt_ctl_t    ctl,
  output gdt_pkg::gdt_status_t st,
  input  logic [1:0]           command,
  input  logic [3:0]           vertex_a,
  input  logic [3:0]           vertex_b,
  input  logic                 cfg_write,
  input  logic [4:0]           cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [4:0]           visit_number,
  output logic [3:0]           visited_vertex,
  output logic                 last,
  output logic                 edge_dropped
);
  import gdt_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int AW = $clog2(MAX_VERTICES * MAX_DEGREE);
  localparam int LW = (CW > 5) ? CW : 5;
  localparam int NT_DEPTH = MAX_VERTICES * MAX_DEGREE;

  logic [4:0]    vcount;
  logic [LW-1:0] n_live;
  logic          mode_dfs;
  logic [3:0]    ra, rb;
  logic          dropped;

  logic [DW-1:0] deg [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] mark;
  logic [CW-1:0] vcnt;
  logic [VW-1:0] nt [NT_DEPTH];
  logic [VW-1:0] rd;
  logic [VW-1:0] stack_v   [MAX_VERTICES];
  logic [DW-1:0] stack_pos [MAX_VERTICES];
  logic [CW-1:0] sp;
  logic [VW-1:0] queue [MAX_VERTICES];
  logic [CW-1:0] head, tail;
  logic [CW-1:0] s;
  logic [VW-1:0] cur_v;
  logic [DW-1:0] cur_k;
  logic [DW-1:0] da;
  logic          pend_valid;
  logic [VW-1:0] pend_v;
  logic [CW-1:0] pend_num;

  logic [VW-1:0] a_idx, b_idx, s_idx, top_idx, q_v, vis_v, deg_addr;
  logic [DW-1:0] deg_rd, top_pos;
  logic          a_in, b_in, w_ok, out_free, push_out;
  logic [AW-1:0] wr_addr, rd_addr;

  assign n_live = (LW'(vcount) > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : LW'(vcount);
  assign a_idx  = VW'(ra);
  assign b_idx  = VW'(rb);
  assign s_idx  = VW'(s);
  assign top_idx = VW'(sp - 1'b1);
  assign top_pos = stack_pos[top_idx];
  assign q_v    = queue[VW'(head)];
  assign a_in   = LW'(ra) < n_live;
  assign b_in   = LW'(rb) < n_live;
  assign w_ok   = (LW'(rd) < n_live) && !mark[rd];
  assign vis_v  = ctl.visit_start ? s_idx : rd;
  assign out_free = !out_valid || !out_stall;
  assign push_out = (ctl.visit && pend_valid) || ctl.flush;

  always_comb begin
    case (ctl.deg_sel)
      DSEL_A:  deg_addr = a_idx;
      DSEL_B:  deg_addr = b_idx;
      DSEL_S:  deg_addr = s_idx;
      DSEL_W:  deg_addr = rd;
      DSEL_Q:  deg_addr = q_v;
      default: deg_addr = a_idx;
    endcase
  end
  assign deg_rd = deg[deg_addr];

  always_comb begin
    st.mode_dfs = mode_dfs;
    st.add_ok   = a_in && b_in &&
                  ((ra == rb) ? ((DW+2)'(da) + (DW+2)'(2) <= (DW+2)'(MAX_DEGREE))
                              : ((DW+1)'(da) < (DW+1)'(MAX_DEGREE) &&
                                 (DW+1)'(deg_rd) < (DW+1)'(MAX_DEGREE)));
    st.s_done       = LW'(s) >= n_live;
    st.s_marked     = mark[s_idx];
    st.sp_zero      = (sp == '0);
    st.top_pos_zero = (top_pos == '0);
    st.w_new_dfs    = w_ok && (sp < CW'(MAX_VERTICES));
    st.w_new_bfs    = w_ok && (tail < CW'(MAX_VERTICES));
    st.q_empty      = (head == tail);
    st.k_zero       = (cur_k == '0);
    st.pend_valid   = pend_valid;
    st.out_free     = out_free;
  end

  // neighbor table: one write and one registered read per cycle
  assign wr_addr = ctl.add_first ? AW'(AW'(a_idx) * AW'(MAX_DEGREE) + AW'(da))
                                 : AW'(AW'(b_idx) * AW'(MAX_DEGREE) + AW'(deg_rd));
  assign rd_addr = ctl.pos_dec ? AW'(AW'(stack_v[top_idx]) * AW'(MAX_DEGREE)
                                     + AW'(top_pos - 1'b1))
                               : AW'(AW'(cur_v) * AW'(MAX_DEGREE) + AW'(cur_k - 1'b1));

  always_ff @(posedge clk) begin
    if (ctl.add_first) begin
      nt[wr_addr] <= b_idx;
    end else if (ctl.add_second) begin
      nt[wr_addr] <= a_idx;
    end
    if (ctl.pos_dec || ctl.bfs_read) begin
      rd <= nt[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount     <= VCOUNT_RESET;
      dropped    <= 1'b0;
      mark       <= '0;
      vcnt       <= '0;
      sp         <= '0;
      head       <= '0;
      tail       <= '0;
      s          <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        deg[i] <= '0;
      end
    end else begin
      if (cfg_write) vcount <= cfg_data;
      if (ctl.clear) begin
        dropped <= 1'b0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
          deg[i] <= '0;
        end
      end
      if (ctl.set_drop) dropped <= 1'b1;
      if (ctl.add_first)  deg[a_idx] <= da + 1'b1;
      if (ctl.add_second) deg[b_idx] <= deg_rd + 1'b1;
      if (ctl.run_init) begin
        mark       <= '0;
        vcnt       <= '0;
        s          <= '0;
        pend_valid <= 1'b0;
      end
      if (ctl.s_inc) s <= s + 1'b1;
      if (ctl.visit) begin
        vcnt        <= vcnt + 1'b1;
        mark[vis_v] <= 1'b1;
        pend_valid  <= 1'b1;
      end
      if (ctl.flush) pend_valid <= 1'b0;
      if (ctl.dfs_start) sp <= CW'(1);
      if (ctl.sp_dec)    sp <= sp - 1'b1;
      if (ctl.dfs_push)  sp <= sp + 1'b1;
      if (ctl.bfs_start) begin
        head <= '0;
        tail <= CW'(1);
      end
      if (ctl.bfs_pop) head <= head + 1'b1;
      if (ctl.bfs_enq) tail <= tail + 1'b1;
      if (push_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      ra       <= vertex_a;
      rb       <= vertex_b;
      mode_dfs <= (gdt_cmd_t'(command) == CMD_DFS);
    end
    if (ctl.add_cap) da <= deg_rd;
    if (ctl.visit) begin
      pend_v   <= vis_v;
      pend_num <= vcnt + 1'b1;
    end
    if (ctl.dfs_start) begin
      stack_v[0]   <= s_idx;
      stack_pos[0] <= deg_rd;
    end
    if (ctl.pos_dec) stack_pos[top_idx] <= top_pos - 1'b1;
    if (ctl.dfs_push) begin
      stack_v[VW'(sp)]   <= rd;
      stack_pos[VW'(sp)] <= deg_rd;
    end
    if (ctl.bfs_start) queue[0] <= s_idx;
    if (ctl.bfs_enq)   queue[VW'(tail)] <= rd;
    if (ctl.bfs_pop) begin
      cur_v <= q_v;
      cur_k <= deg_rd;
    end
    if (ctl.bfs_read) cur_k <= cur_k - 1'b1;
    if (push_out) begin
      visit_number   <= 5'(pend_num);
      visited_vertex <= 4'(pend_v);
      last           <= ctl.flush;
      edge_dropped   <= dropped;
    end
  end

endmodule

// File: rtl/graph_dfs_bfs_traversal.sv
// Graph search engine for undirected graphs of up to MAX_VERTICES vertices with at most
// MAX_DEGREE neighbors each. Command clear (0) empties all neighbor lists and the sticky
// edge_dropped flag; add edge (1) appends vertex_b to vertex_a's list and vertex_a to
// vertex_b's, or drops the edge and sets edge_dropped when an endpoint is not below the
// vertex count or a list is full; depth first (2) and breadth first (3) visit every
// vertex below the vertex count, starting from each unvisited vertex in index order and
// scanning neighbor lists newest entry first, and deliver one transfer per vertex with
// its visit number and index, last set on the final one. Edge loads and clears produce
// no output. An add edge reads the degree table once per endpoint and takes one write
// per endpoint in the neighbor memory; the pace of a run is set by the single registered
// read port of the neighbor memory. One command is worked on at a time and in_stall
// stays high until the last result is handed to the output register. vertex_count is
// written over the cfg port (always ready); the user must write it only while idle,
// which the block does not enforce.
module graph_dfs_bfs_traversal #(
  parameter int MAX_VERTICES = gdt_pkg::MAX_VERTICES_DEF,
  parameter int MAX_DEGREE   = gdt_pkg::MAX_DEGREE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [3:0] vertex_a,
  input  logic [3:0] vertex_b,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] visit_number,
  output logic [3:0] visited_vertex,
  output logic       last,
  output logic       edge_dropped,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);
  import gdt_pkg::*;

  gdt_ctl_t    ctl;
  gdt_status_t st;

  // the count register is always ready; writes must only happen while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  gdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .st       (st),
    .ctl      (ctl),
    .in_stall (in_stall)
  );

  gdt_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .st             (st),
    .command        (command),
    .vertex_a       (vertex_a),
    .vertex_b       (vertex_b),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .visit_number   (visit_number),
    .visited_vertex (visited_vertex),
    .last           (last),
    .edge_dropped   (edge_dropped)
  );

  // a run command holds off the input side on the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command[1]) |=> in_stall)
    else $error("run accepted but input not held");

  // visit numbers start at one
  a_visit_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (visit_number != 5'd0))
    else $error("visit number zero");

  // a result is only produced while a run is in progress
  a_out_in_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(in_stall))
    else $error("result outside a run");

endmodule
